>>> design/assert_macros.svh
// Assertion macros shared by the RC4 keystream generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RC4_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc4 assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RC4_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc4 assertion failed: next-cycle implication");

`endif

>>> design/rc4_pkg.sv
// Shared types and constants for the RC4 keystream generator.
package rc4_pkg;

  localparam int BYTE_W            = 8;
  localparam int SBOX_DEPTH        = 256;
  localparam int MAX_KEY_BYTES_DEF = 256;

  // Request opcodes
  localparam logic OP_LOAD_KEY = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_KEY_TAKEN  = 2'd0,
    ST_SCHED_DONE = 2'd1,
    ST_KEYSTREAM  = 2'd2,
    ST_NOT_SEEDED = 2'd3
  } rc4_status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic        accept;    // request taken this cycle
    logic        fill;      // write identity entry S[k] = k
    logic        ks_rd;     // schedule: read S[k] and key byte
    logic        ks_j;      // schedule: update j, read S[j]
    logic        ks_w1;     // schedule: write S[k]
    logic        ks_w2;     // schedule: write S[j], advance k
    logic        g_i;       // generate: advance i, read S[i]
    logic        g_j;       // generate: update j, read S[j]
    logic        g_w1;      // generate: write S[i], read S[t]
    logic        g_w2;      // generate: write S[j], form output byte
    logic        set_res;   // capture result code
    rc4_status_t res_code;
    logic        load_out;  // move result into output register
  } rc4_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic seeded;
    logic k_last;
    logic out_free;
  } rc4_stat_t;

endpackage

>>> design/rc4_keystream_generator_core.sv
// Top level of the RC4 keystream generator: controller plus datapath.
//
// Input channel (in_valid / in_stall) carries one request: opcode 0 appends
// key_byte to the key store (bytes past MAX_KEY_BYTES are dropped), and with
// last_key_byte set it also runs the key schedule. Opcode 1 asks for one
// keystream byte. Every request gives exactly one result on the output
// channel (out_valid / out_stall): out_byte and status (0 key byte taken,
// 1 schedule done, 2 keystream byte, 3 not seeded).
// Work per request, from accept to the next accept:
//   key byte or unseeded generate: the result step only
//   keystream byte: four S-box memory steps, then the result
//   key schedule: an identity fill of the S-box, one swap per entry, then the result
// The S-box is one memory with a single write port, so each swap needs two
// write steps; the schedule's dependent reads and writes set its length.
// The result register moves into the output register when it is free. A new
// request is accepted while that result still waits; if the receiver keeps
// out_stall high, the following result holds inside until the output frees.
// Reset clears the key count, both indices, the seeded flag and out_valid.
module rc4_keystream_generator_core
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [BYTE_W-1:0] key_byte,
  input  logic              last_key_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic [1:0]        status
);

  rc4_cmd_t  cmd;
  rc4_stat_t stat;

  // Sequencer
  rc4_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .last_key_byte (last_key_byte),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Storage and arithmetic
  rc4_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .opcode    (opcode),
    .key_byte  (key_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .status    (status)
  );

endmodule

>>> design/rc4_ctrl.sv
// Controller state machine for the RC4 keystream generator.
`include "assert_macros.svh"

module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      opcode,
  input  logic      last_key_byte,
  input  rc4_stat_t stat,
  output rc4_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_FILL  = 12'b0000_0000_0010,
    S_KS_RD = 12'b0000_0000_0100,
    S_KS_J  = 12'b0000_0000_1000,
    S_KS_W1 = 12'b0000_0001_0000,
    S_KS_W2 = 12'b0000_0010_0000,
    S_G_I   = 12'b0000_0100_0000,
    S_G_J   = 12'b0000_1000_0000,
    S_G_W1  = 12'b0001_0000_0000,
    S_G_W2  = 12'b0010_0000_0000,
    S_FIN   = 12'b0100_0000_0000,
    S_SPARE = 12'b1000_0000_0000
  } ctl_state_t;

  ctl_state_t state, state_next;

  // Requests are taken only between operations
  assign in_stall = (state != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_code = ST_KEY_TAKEN;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (opcode == OP_LOAD_KEY) begin
            if (last_key_byte) begin
              state_next = S_FILL;
            end else begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_KEY_TAKEN;
              state_next   = S_FIN;
            end
          end else if (!stat.seeded) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NOT_SEEDED;
            state_next   = S_FIN;
          end else begin
            state_next = S_G_I;
          end
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.k_last) begin
          state_next = S_KS_RD;
        end
      end
      S_KS_RD: begin
        cmd.ks_rd  = 1'b1;
        state_next = S_KS_J;
      end
      S_KS_J: begin
        cmd.ks_j   = 1'b1;
        state_next = S_KS_W1;
      end
      S_KS_W1: begin
        cmd.ks_w1  = 1'b1;
        state_next = S_KS_W2;
      end
      S_KS_W2: begin
        cmd.ks_w2 = 1'b1;
        if (stat.k_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_SCHED_DONE;
          state_next   = S_FIN;
        end else begin
          state_next = S_KS_RD;
        end
      end
      S_G_I: begin
        cmd.g_i    = 1'b1;
        state_next = S_G_J;
      end
      S_G_J: begin
        cmd.g_j    = 1'b1;
        state_next = S_G_W1;
      end
      S_G_W1: begin
        cmd.g_w1   = 1'b1;
        state_next = S_G_W2;
      end
      S_G_W2: begin
        cmd.g_w2     = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_KEYSTREAM;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A generate request before seeding goes straight to the result
  `RC4_ASSERT_NEXT(a_unseeded_direct, in_valid && !in_stall && opcode == OP_GENERATE && !stat.seeded, state == S_FIN)
  // Keystream work only starts once seeded
  `RC4_ASSERT_IMPL(a_gen_seeded, state == S_G_I, stat.seeded)

endmodule

>>> design/rc4_datapath.sv
// Datapath for the RC4 keystream generator: S-box, key store, indices, output register.
`include "assert_macros.svh"

module rc4_datapath
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rc4_cmd_t          cmd,
  output rc4_stat_t         stat,
  input  logic              opcode,
  input  logic [BYTE_W-1:0] key_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic [1:0]        status
);

  localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KCW    = $clog2(MAX_KEY_BYTES + 1);

  // Storage
  logic [BYTE_W-1:0] sbox_mem [SBOX_DEPTH];
  logic [BYTE_W-1:0] key_mem  [MAX_KEY_BYTES];

  // Control state
  logic              seeded;
  logic [KCW-1:0]    key_count;
  logic [BYTE_W-1:0] i;
  logic [BYTE_W-1:0] j;

  // Working registers
  logic [BYTE_W-1:0] k;
  logic [KEY_AW-1:0] kidx;
  logic [BYTE_W-1:0] sj;
  logic [BYTE_W-1:0] sa;
  logic [BYTE_W-1:0] sb;
  logic              hit_i;
  logic              hit_j;
  logic [BYTE_W-1:0] rd_a;
  logic [BYTE_W-1:0] rd_b;
  logic [BYTE_W-1:0] key_rd;
  logic [BYTE_W-1:0] res_byte;
  rc4_status_t       res_status;

  // Combinational datapath
  logic              sb_we;
  logic [BYTE_W-1:0] sb_wa;
  logic [BYTE_W-1:0] sb_wd;
  logic              rd_a_en;
  logic [BYTE_W-1:0] rd_a_addr;
  logic              rd_b_en;
  logic [BYTE_W-1:0] rd_b_addr;
  logic [BYTE_W-1:0] ks_key;
  logic [BYTE_W-1:0] ks_jn;
  logic [BYTE_W-1:0] g_jn;
  logic [BYTE_W-1:0] i_inc;
  logic [BYTE_W-1:0] tn;
  logic [BYTE_W-1:0] ks_byte;
  logic              key_we;
  logic              key_wrap;
  logic              out_free;

  assign out_free = !out_valid || !out_stall;
  assign stat     = '{seeded: seeded, k_last: (k == {BYTE_W{1'b1}}), out_free: out_free};

  // Empty key reads as a single zero byte
  assign ks_key   = (key_count == '0) ? '0 : key_rd;
  assign ks_jn    = sj + rd_a + ks_key;
  assign g_jn     = j + rd_a;
  assign i_inc    = i + BYTE_W'(1);
  assign tn       = sa + rd_b;
  assign key_we   = cmd.accept && (opcode == OP_LOAD_KEY) &&
                    (key_count < KCW'(MAX_KEY_BYTES));
  assign key_wrap = ((KCW'(kidx) + KCW'(1)) == key_count);

  // Output byte with forwarding of the two swap writes (S[j] write wins)
  assign ks_byte = hit_j ? sa : (hit_i ? sb : rd_a);

  // S-box port steering
  always_comb begin
    sb_we     = 1'b0;
    sb_wa     = '0;
    sb_wd     = '0;
    rd_a_en   = 1'b0;
    rd_a_addr = '0;
    rd_b_en   = 1'b0;
    rd_b_addr = '0;
    if (cmd.fill) begin
      sb_we = 1'b1;
      sb_wa = k;
      sb_wd = k;
    end
    if (cmd.ks_rd) begin
      rd_a_en   = 1'b1;
      rd_a_addr = k;
    end
    if (cmd.ks_j) begin
      rd_b_en   = 1'b1;
      rd_b_addr = ks_jn;
    end
    if (cmd.ks_w1) begin
      sb_we = 1'b1;
      sb_wa = k;
      sb_wd = rd_b;
    end
    if (cmd.ks_w2) begin
      sb_we = 1'b1;
      sb_wa = sj;
      sb_wd = sa;
    end
    if (cmd.g_i) begin
      rd_a_en   = 1'b1;
      rd_a_addr = i_inc;
    end
    if (cmd.g_j) begin
      rd_b_en   = 1'b1;
      rd_b_addr = g_jn;
    end
    if (cmd.g_w1) begin
      sb_we     = 1'b1;
      sb_wa     = i;
      sb_wd     = rd_b;
      rd_a_en   = 1'b1;
      rd_a_addr = tn;
    end
    if (cmd.g_w2) begin
      sb_we = 1'b1;
      sb_wa = j;
      sb_wd = sa;
    end
  end

  // S-box memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (sb_we) begin
      sbox_mem[sb_wa] <= sb_wd;
    end
    if (rd_a_en) begin
      rd_a <= sbox_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b <= sbox_mem[rd_b_addr];
    end
  end

  // Key store memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count[KEY_AW-1:0]] <= key_byte;
    end
    if (cmd.ks_rd) begin
      key_rd <= key_mem[kidx];
    end
  end

  // Schedule counters and swap operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k    <= '0;
      kidx <= '0;
      sj   <= '0;
    end
    if (cmd.fill) begin
      k <= k + BYTE_W'(1);
    end
    if (cmd.ks_j) begin
      sj <= ks_jn;
      sa <= rd_a;
    end
    if (cmd.ks_w2) begin
      k    <= k + BYTE_W'(1);
      kidx <= key_wrap ? '0 : kidx + KEY_AW'(1);
    end
    if (cmd.g_j) begin
      sa <= rd_a;
    end
    if (cmd.g_w1) begin
      sb    <= rd_b;
      hit_i <= (tn == i);
      hit_j <= (tn == j);
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_byte   <= (cmd.res_code == ST_KEYSTREAM) ? ks_byte : '0;
    end
  end

  // Seed state, key count and indices
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded    <= 1'b0;
      key_count <= '0;
      i         <= '0;
      j         <= '0;
    end else begin
      if (key_we) begin
        key_count <= key_count + KCW'(1);
      end
      if (cmd.g_i) begin
        i <= i_inc;
      end
      if (cmd.g_j) begin
        j <= g_jn;
      end
      if (cmd.ks_w2 && stat.k_last) begin
        seeded    <= 1'b1;
        key_count <= '0;
        i         <= '0;
        j         <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte <= res_byte;
      status   <= res_status;
    end
  end

  // Result never overwrites a result still waiting at the output
  `RC4_ASSERT_IMPL(a_load_has_room, cmd.load_out, !out_valid || !out_stall)
  // Key count stays within the key store
  `RC4_ASSERT_IMPL(a_count_bound, 1'b1, key_count <= KCW'(MAX_KEY_BYTES))
  // End of schedule seeds the block and restarts the key
  `RC4_ASSERT_NEXT(a_sched_seeds, cmd.ks_w2 && stat.k_last, seeded && key_count == '0 && i == '0 && j == '0)

endmodule
